/* design/tssg_pkg.sv */
// Package for the triangle scanline span generator.
// Holds shared widths, phase codes, division selectors and the controller/datapath command and status structs.
package tssg_pkg;

	localparam int COORD_W = 16;
	localparam int ROW_W = 12;
	localparam int ACC_W = 32;
	localparam int COLOR_W = 32;
	localparam int DEF_COORD_FRAC_BITS = 4;
	localparam int DEF_SLOPE_FRAC_BITS = 16;

	// Walk phases.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_UPPER_THEN_LOWER = 2'd1;
	localparam logic [1:0] PH_UPPER_ONLY = 2'd2;
	localparam logic [1:0] PH_LOWER = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // Capture and sort vertices.
		logic div_start; // Start a division.
		logic [2:0] div_sel; // Which quotient is being formed.
		logic begin_up;  // Set up the upper walk.
		logic begin_lo;  // Set up the lower walk.
		logic step_up;   // Advance the upper walk.
		logic step_lo;   // Advance the lower walk.
	} cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic flat_top;
		logic flat_bot;
		logic div_done;
		logic up_ok;     // First upper row passes its test.
		logic lo_ok;     // First lower row passes its test.
		logic up_more;   // Next upper row still passes.
		logic lo_more;   // Next lower row still passes.
	} stat_t;

	// Division selectors.
	localparam logic [2:0] DV_SPLIT = 3'd0;
	localparam logic [2:0] DV_S0 = 3'd1;
	localparam logic [2:0] DV_S1 = 3'd2;
	localparam logic [2:0] DV_S2 = 3'd3;
	localparam logic [2:0] DV_S3 = 3'd4;
	localparam logic [2:0] DV_NONE = 3'd7; // No division selected yet, or sequence done.

endpackage

/* design/tssg_div.sv */
// Iterative signed divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module tssg_div #(
	parameter int W = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic done,
	output logic signed [W-1:0] quo
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] n_q, d_q, q_q;
	logic [W:0] r_q;
	logic [CW-1:0] cnt_q;
	logic neg_q, busy_q;
	logic [W:0] r_sh, r_sub;

	always_comb begin
		r_sh = {r_q[W-1:0], n_q[W-1]};
		r_sub = r_sh - {1'b0, d_q};
	end

	// Restoring division on magnitudes; sign fixed at the end (truncation).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num[W-1] ? -num : num;
			d_q <= den[W-1] ? -den : den;
			neg_q <= num[W-1] ^ den[W-1];
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[W-2:0], 1'b0};
			if (!r_sub[W]) begin
				r_q <= r_sub;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

/* design/tssg_datapath.sv */
// Datapath: vertex sort, shared divider, edge accumulators and row counter.
// Depends on tssg_pkg and tssg_div.
module tssg_datapath #(
	parameter int COORD_FRAC_BITS = tssg_pkg::DEF_COORD_FRAC_BITS,
	parameter int SLOPE_FRAC_BITS = tssg_pkg::DEF_SLOPE_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  tssg_pkg::cmd_t cmd,
	output tssg_pkg::stat_t stat,
	input  logic signed [15:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy,
	input  logic [31:0] in_color,
	output logic signed [11:0] o_y,
	output logic signed [11:0] o_xs,
	output logic signed [11:0] o_xe,
	output logic [31:0] o_color
);
	import tssg_pkg::*;

	localparam int DW = 50;
	localparam int RW = 20;
	// Biases added to negative values so that an arithmetic shift truncates toward zero.
	localparam logic signed [31:0] SLOPE_RND = 32'((64'sd1 <<< SLOPE_FRAC_BITS) - 64'sd1);
	localparam logic signed [16:0] COORD_RND = 17'((32'sd1 <<< COORD_FRAC_BITS) - 32'sd1);

	logic signed [15:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
	logic signed [31:0] spx_q;
	logic [31:0] color_q;
	logic signed [31:0] sl0_q, sl1_q, sl2_q, sl3_q;
	logic signed [31:0] lacc_q, racc_q;
	logic signed [RW-1:0] row_q;

	// Sorting network (three compare-swaps).
	logic signed [15:0] ax, ay, bx, by, cx, cy, tx, ty;
	always_comb begin
		ax = in_ax; ay = in_ay; bx = in_bx; by = in_by; cx = in_cx; cy = in_cy;
		tx = in_ax; ty = in_ay;
		if (ay > by) begin tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty; end
		if (by > cy) begin tx = bx; ty = by; bx = cx; by = cy; cx = tx; cy = ty; end
		if (ay > by) begin tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty; end
	end

	// Divider operands.
	logic signed [DW-1:0] num, den, quo;
	logic signed [31:0] dx, dy;
	logic signed [16:0] pdx, pdy;
	logic signed [33:0] prod;
	assign pdx = 17'(x2_q) - 17'(x0_q);
	assign pdy = 17'(y1_q) - 17'(y0_q);
	assign prod = 34'(pdx) * 34'(pdy);
	always_comb begin
		dx = '0; dy = '0;
		case (cmd.div_sel)
			DV_S0: begin dx = 32'(x1_q) - 32'(x0_q); dy = 32'(y1_q) - 32'(y0_q); end
			DV_S1: begin
				dx = spx_q - 32'(x0_q);
				dy = stat.flat_bot ? 32'(y2_q) - 32'(y0_q) : 32'(y1_q) - 32'(y0_q);
			end
			DV_S2: begin dx = 32'(x1_q) - 32'(x2_q); dy = 32'(y1_q) - 32'(y2_q); end
			DV_S3: begin
				dx = spx_q - 32'(x2_q);
				dy = stat.flat_top ? 32'(y0_q) - 32'(y2_q) : 32'(y1_q) - 32'(y2_q);
			end
			default: begin dx = '0; dy = '0; end
		endcase
		if (cmd.div_sel == DV_SPLIT) begin
			num = DW'(prod);
			den = DW'(32'(y2_q) - 32'(y0_q));
		end else begin
			num = DW'(dx) <<< SLOPE_FRAC_BITS;
			den = DW'(dy);
		end
	end
	logic dz_q;
	tssg_div #(.W(DW)) u_div (.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num), .den(den), .done(stat.div_done), .quo(quo));

	function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
		if (v > DW'(32'sh7fffffff)) return 32'sh7fffffff;
		if (v < -DW'(33'sh080000000)) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [11:0] col(input logic signed [31:0] a);
		logic signed [31:0] q;
		q = (a + (a[31] ? SLOPE_RND : 32'sd0)) >>> SLOPE_FRAC_BITS;
		if (q > 32'sd2047) return 12'sd2047;
		if (q < -32'sd2048) return -12'sd2048;
		return q[11:0];
	endfunction

	logic signed [DW-1:0] s_up_l, s_up_r, s_lo_l, s_lo_r;
	assign s_up_l = DW'(lacc_q) + DW'(sl0_q);
	assign s_up_r = DW'(racc_q) + DW'(sl1_q);
	assign s_lo_l = DW'(lacc_q) - DW'(sl2_q);
	assign s_lo_r = DW'(racc_q) - DW'(sl3_q);

	// First rows of the two halves, the vertex rows truncated toward zero.
	logic signed [16:0] y0_b, y2_b;
	logic signed [RW-1:0] r0, r2;
	assign y0_b = 17'(y0_q) + (y0_q[15] ? COORD_RND : 17'sd0);
	assign y2_b = 17'(y2_q) + (y2_q[15] ? COORD_RND : 17'sd0);
	assign r0 = RW'(y0_b >>> COORD_FRAC_BITS);
	assign r2 = RW'(y2_b >>> COORD_FRAC_BITS);
	function automatic logic signed [RW+8:0] rs(input logic signed [RW-1:0] r);
		return (RW+9)'(r) <<< COORD_FRAC_BITS;
	endfunction

	assign stat.flat_top = (y0_q == y1_q);
	assign stat.flat_bot = (y2_q == y1_q);
	assign stat.up_ok = rs(r0) <= (RW+9)'(y1_q);
	assign stat.lo_ok = rs(r2) >= (RW+9)'(y1_q);
	assign stat.up_more = rs(row_q + 1'b1) <= (RW+9)'(y1_q);
	assign stat.lo_more = rs(row_q - 1'b1) >= (RW+9)'(y1_q);

	// Result word from the current walk state.
	assign o_y = row_q[11:0];
	assign o_xs = col(lacc_q);
	assign o_xe = col(racc_q);
	assign o_color = color_q;

	// Vertex x coordinate scaled to the accumulator format.
	function automatic logic signed [31:0] to_acc(input logic signed [15:0] x);
		return sat32(DW'(x) <<< (SLOPE_FRAC_BITS - COORD_FRAC_BITS));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x0_q <= '0; y0_q <= '0; x1_q <= '0; y1_q <= '0; x2_q <= '0; y2_q <= '0;
			spx_q <= '0; color_q <= '0; sl0_q <= '0; sl1_q <= '0; sl2_q <= '0;
			sl3_q <= '0; lacc_q <= '0; racc_q <= '0; row_q <= '0; dz_q <= 1'b0;
		end else begin
			if (cmd.div_start) dz_q <= (den == '0);
			if (cmd.load) begin
				x0_q <= ax; y0_q <= ay; x1_q <= bx; y1_q <= by; x2_q <= cx; y2_q <= cy;
				color_q <= in_color;
				sl0_q <= '0; sl1_q <= '0; sl2_q <= '0; sl3_q <= '0;
				if (ay == by) spx_q <= 32'(ax);
				else if (cy == by) spx_q <= 32'(cx);
			end
			if (stat.div_done) begin
				case (cmd.div_sel)
					DV_SPLIT: spx_q <= quo[31:0] + 32'(x0_q);
					DV_S0: sl0_q <= dz_q ? '0 : sat32(quo);
					DV_S1: sl1_q <= dz_q ? '0 : sat32(quo);
					DV_S2: sl2_q <= dz_q ? '0 : sat32(quo);
					DV_S3: sl3_q <= dz_q ? '0 : sat32(quo);
					default: ;
				endcase
			end
			if (cmd.begin_up) begin
				row_q <= r0; lacc_q <= to_acc(x0_q); racc_q <= to_acc(x0_q);
			end else if (cmd.begin_lo) begin
				row_q <= r2; lacc_q <= to_acc(x2_q); racc_q <= to_acc(x2_q);
			end else if (cmd.step_up) begin
				row_q <= row_q + 1'b1; lacc_q <= sat32(s_up_l); racc_q <= sat32(s_up_r);
			end else if (cmd.step_lo) begin
				row_q <= row_q - 1'b1; lacc_q <= sat32(s_lo_l); racc_q <= sat32(s_lo_r);
			end
		end
	end
endmodule

/* design/tssg_ctrl.sv */
// Controller: load sequencing through the divider, phase tracking, handshake.
// Depends on tssg_pkg.
module tssg_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_kind,
	output logic out_valid,
	input  logic out_ready,
	output logic out_last,
	output tssg_pkg::cmd_t cmd,
	input  tssg_pkg::stat_t stat
);
	import tssg_pkg::*;

	localparam logic [2:0] S_READY = 3'd0;
	localparam logic [2:0] S_DIV = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_BEGIN = 3'd3;

	logic [2:0] st_q;
	logic [1:0] ph_q;
	logic [2:0] sel_q;
	logic acc_in;
	logic span_go;
	logic span_last;

	assign in_ready = (st_q == S_READY) && (!out_valid || out_ready);
	assign acc_in = in_valid && in_ready;
	assign span_go = acc_in && in_kind && (ph_q != PH_IDLE);

	// A span is the last one when its half ends and no lower half follows.
	always_comb begin
		case (ph_q)
			PH_LOWER: span_last = !stat.lo_more;
			PH_UPPER_ONLY: span_last = !stat.up_more;
			PH_UPPER_THEN_LOWER: span_last = !stat.up_more && !stat.lo_ok;
			default: span_last = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = sel_q;
		cmd.load = acc_in && !in_kind;
		cmd.div_start = (st_q == S_DIV);
		cmd.begin_up = (st_q == S_BEGIN) && (ph_q == PH_IDLE) && !stat.flat_top && stat.up_ok;
		cmd.begin_lo = (st_q == S_BEGIN) && !cmd.begin_up
			&& (stat.flat_top || !stat.flat_bot) && stat.lo_ok;
		cmd.step_up = span_go && (ph_q == PH_UPPER_THEN_LOWER || ph_q == PH_UPPER_ONLY);
		cmd.step_lo = span_go && (ph_q == PH_LOWER);
	end

	// Slope sequence per case.
	function automatic logic [2:0] first_sel(input logic ft, input logic fb);
		if (ft) return DV_S2;
		if (fb) return DV_S0;
		return DV_SPLIT;
	endfunction
	function automatic logic [2:0] next_sel(input logic [2:0] s, input logic fb);
		case (s)
			DV_SPLIT: return DV_S0;
			DV_S0: return DV_S1;
			DV_S1: return fb ? DV_NONE : DV_S2;
			DV_S2: return DV_S3;
			default: return DV_NONE;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_READY; ph_q <= PH_IDLE; sel_q <= DV_SPLIT;
			out_valid <= 1'b0; out_last <= 1'b0;
		end else begin
			out_valid <= span_go || (out_valid && !out_ready);
			if (span_go) out_last <= span_last;
			case (st_q)
				S_READY: begin
					if (cmd.load) begin
						st_q <= S_DIV;
						ph_q <= PH_IDLE;
						sel_q <= DV_NONE;
					end else if (span_go) begin
						if (ph_q == PH_LOWER) begin
							if (!stat.lo_more) ph_q <= PH_IDLE;
						end else if (!stat.up_more) begin
							if (ph_q == PH_UPPER_THEN_LOWER) st_q <= S_BEGIN;
							else ph_q <= PH_IDLE;
						end
					end
				end
				S_DIV: begin
					// First cycle after load: pick the division sequence; later visits go on to wait.
					if (sel_q == DV_NONE) sel_q <= first_sel(stat.flat_top, stat.flat_bot);
					st_q <= (sel_q == DV_NONE) ? S_DIV : S_WAIT;
				end
				S_WAIT: begin
					if (stat.div_done) begin
						if (next_sel(sel_q, stat.flat_bot) == DV_NONE) st_q <= S_BEGIN;
						else begin sel_q <= next_sel(sel_q, stat.flat_bot); st_q <= S_DIV; end
					end
				end
				S_BEGIN: begin
					st_q <= S_READY;
					if (cmd.begin_up)
						ph_q <= stat.flat_bot ? PH_UPPER_ONLY : PH_UPPER_THEN_LOWER;
					else if (cmd.begin_lo)
						ph_q <= PH_LOWER;
					else
						ph_q <= PH_IDLE;
				end
				default: st_q <= S_READY;
			endcase
		end
	end
endmodule

/* design/triangle_scanline_span_generator.sv */
// Top level of the triangle scanline span generator.
// Depends on tssg_pkg, tssg_ctrl, tssg_datapath and tssg_div.
//
// A load word (tuser 0) sorts three 12.4 vertices and forms the split point and
// up to four inverse slopes with one shared bit-serial divider: after a setup
// state, two divisions for a flat-top or flat-bottom triangle and five for a
// general one, then a walk-seeding state; only then is the next word taken.
// A step word (tuser 1) yields one span from the edge accumulators; it appears in
// the output register the cycle after the step is taken, and steps flow one per
// cycle while the output drains. A step that ends the upper half holds off the
// next word while the lower half is seeded. last marks the final span.
module triangle_scanline_span_generator #(
	parameter int COORD_FRAC_BITS = tssg_pkg::DEF_COORD_FRAC_BITS,
	parameter int SLOPE_FRAC_BITS = tssg_pkg::DEF_SLOPE_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x,
	// vertex_c_y, fill_color
	input  logic [127:0] s_tdata,
	input  logic s_tuser, // kind
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: span_y, span_x_start, span_x_end, span_color, zero pad
	output logic [71:0] m_tdata,
	output logic m_tlast
);
	import tssg_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic signed [11:0] oy, oxs, oxe;
	logic [31:0] ocol;
	logic [67:0] res_q;

	tssg_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_kind(s_tuser), .out_valid(m_tvalid), .out_ready(m_tready),
		.out_last(m_tlast), .cmd(cmd), .stat(stat));

	tssg_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_ax(s_tdata[15:0]), .in_ay(s_tdata[31:16]), .in_bx(s_tdata[47:32]),
		.in_by(s_tdata[63:48]), .in_cx(s_tdata[79:64]), .in_cy(s_tdata[95:80]),
		.in_color(s_tdata[127:96]), .o_y(oy), .o_xs(oxs), .o_xe(oxe), .o_color(ocol));

	// Output register, captured when a span is taken.
	always_ff @(posedge clk) begin
		if (cmd.step_up || cmd.step_lo) res_q <= {ocol, oxe, oxs, oy};
	end
	assign m_tdata = {4'b0000, res_q};
endmodule
